// ===== sv/rspn_pkg.sv =====
// Package for the rotated shape pick: table entry layout, field widths, fixed-point
// constants and the controller/datapath command and status structs. No dependencies.
package rspn_pkg;

  localparam int MAX_ENTRIES    = 64;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int SLOT_W         = $clog2(MAX_ENTRIES);
  localparam int COUNT_W        = $clog2(MAX_ENTRIES + 1);

  localparam int POS_W   = 24;
  localparam int TRIG_W  = 16;
  localparam int INV_W   = 20;
  localparam int SHAPE_W = 2;
  localparam int DIST_W  = 51;

  // scaled offset: 8 + trig + 16 fraction bits, 1.0 is 2^ND_FRAC
  localparam int ND_FRAC = 8 + TRIG_FRAC_BITS + 16;
  localparam int ND_DROP = ND_FRAC - 30;

  localparam logic [1:0] SHAPE_BOX = 2'd1;
  localparam logic       MODE_WRITE = 1'b0;
  localparam logic       MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]   center_x;
    logic [POS_W-1:0]   center_z;
    logic [TRIG_W-1:0]  yaw_cos;
    logic [TRIG_W-1:0]  yaw_sin;
    logic [INV_W-1:0]   inv_half_x;
    logic [INV_W-1:0]   inv_half_z;
    logic [SHAPE_W-1:0] shape_kind;
  } entry_t;

  typedef struct packed {
    logic              write_en;
    logic [SLOT_W-1:0] write_slot;
    logic              load_point;
    logic              issue;
    logic [SLOT_W-1:0] issue_idx;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

// ===== sv/rspn_ctrl.sv =====
// Controller for the rotated shape pick: input handshake, slot sequencing,
// drain wait and output valid. Uses rspn_pkg.
module rspn_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  mode,
  input  logic [5:0]            slot,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata,
  input  rspn_pkg::status_t     status,
  output rspn_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {IDLE, ISSUE, DRAIN, DONE} state_t;

  state_t                        state;
  logic [6:0]                    active_count;
  logic [rspn_pkg::COUNT_W-1:0]  count;
  logic [rspn_pkg::SLOT_W-1:0]   idx;
  logic                          out_valid;
  logic                          accept;
  logic [rspn_pkg::COUNT_W-1:0]  count_clamp;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid & s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    if (active_count > 7'(rspn_pkg::MAX_ENTRIES)) begin
      count_clamp = rspn_pkg::COUNT_W'(rspn_pkg::MAX_ENTRIES);
    end else begin
      count_clamp = rspn_pkg::COUNT_W'(active_count);
    end
  end

  always_comb begin
    cmd.write_en   = accept && (mode == rspn_pkg::MODE_WRITE) &&
                     (int'(slot) < rspn_pkg::MAX_ENTRIES);
    cmd.write_slot = rspn_pkg::SLOT_W'(slot);
    cmd.load_point = accept && (mode == rspn_pkg::MODE_QUERY);
    cmd.issue      = (state == ISSUE);
    cmd.issue_idx  = idx;
    cmd.load_out   = (state == DONE) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      active_count <= '0;
      count        <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_count <= cfg_wdata;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd.load_point) begin
            count <= count_clamp;
            idx   <= '0;
            state <= (count_clamp == '0) ? DRAIN : ISSUE;
          end
        end
        ISSUE: begin
          idx <= idx + 1'b1;
          if (rspn_pkg::COUNT_W'(idx) == count - 1'b1) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!status.pipe_busy) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (cmd.load_out) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rspn_dp.sv =====
// Datapath for the rotated shape pick: entry table memory, eight-stage
// containment test, nearest-hit tracking and output register. Uses rspn_pkg.
module rspn_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [175:0]         s_tdata,
  input  rspn_pkg::cmd_t       cmd,
  output rspn_pkg::status_t    status,
  output logic [63:0]          m_tdata,
  output logic [0:0]           m_tuser
);

  localparam int ONE_SH = rspn_pkg::ND_FRAC;

  rspn_pkg::entry_t table_mem [rspn_pkg::MAX_ENTRIES];
  rspn_pkg::entry_t wr_entry;
  logic [rspn_pkg::POS_W-1:0] point_x, point_z;

  assign wr_entry.center_x   = s_tdata[29:6];
  assign wr_entry.center_z   = s_tdata[53:30];
  assign wr_entry.yaw_cos    = s_tdata[69:54];
  assign wr_entry.yaw_sin    = s_tdata[85:70];
  assign wr_entry.inv_half_x = s_tdata[105:86];
  assign wr_entry.inv_half_z = s_tdata[125:106];
  assign wr_entry.shape_kind = s_tdata[127:126];

  // stage valids and slot indexes
  logic [8:1] v;
  logic [rspn_pkg::SLOT_W-1:0] idx1, idx2, idx3, idx4, idx5, idx6, idx7, idx8;

  // stage 1: table read
  rspn_pkg::entry_t e1;
  // stage 2
  logic signed [24:0] dx2, dz2;
  logic signed [15:0] cos2, sin2;
  logic [19:0]        invx2, invz2;
  logic               box2, box3, box4, box5, box6, box7;
  // stage 3
  logic signed [40:0] xc3, zs3, zc3, xs3;
  logic [19:0]        invx3, invz3;
  logic [48:0]        dxx3, dzz3;
  // stage 4
  logic signed [41:0] lx4, lz4;
  logic [19:0]        invx4, invz4;
  logic [49:0]        d2_4, d2_5, d2_6, d2_7, d2_8;
  // stage 5
  logic signed [62:0] nx5, nz5;
  // stage 6
  logic               inb6, inb7;
  logic [30:0]        a6, b6;
  // stage 7
  logic [61:0]        aa7, bb7;
  // stage 8
  logic               hit8;

  // best so far
  logic                        found;
  logic [rspn_pkg::SLOT_W-1:0] best;
  logic [49:0]                 best_d2;

  logic [24:0] mdx, mdz;
  logic [62:0] mnx, mnz;
  logic [62:0] sum_ab;

  always_comb begin
    mdx    = dx2[24] ? 25'(-dx2) : 25'(dx2);
    mdz    = dz2[24] ? 25'(-dz2) : 25'(dz2);
    mnx    = nx5[62] ? 63'(-nx5) : 63'(nx5);
    mnz    = nz5[62] ? 63'(-nz5) : 63'(nz5);
    sum_ab = {1'b0, aa7} + {1'b0, bb7};
  end

  assign status.pipe_busy = |v;

  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      table_mem[cmd.write_slot] <= wr_entry;
    end
    if (cmd.issue) begin
      e1 <= table_mem[cmd.issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[7:1], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      point_x <= s_tdata[151:128];
      point_z <= s_tdata[175:152];
    end
    idx1 <= cmd.issue_idx;
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    idx5 <= idx4;
    idx6 <= idx5;
    idx7 <= idx6;
    idx8 <= idx7;

    // offset from center
    dx2   <= $signed({point_x[23], point_x}) - $signed({e1.center_x[23], e1.center_x});
    dz2   <= $signed({point_z[23], point_z}) - $signed({e1.center_z[23], e1.center_z});
    cos2  <= $signed(e1.yaw_cos);
    sin2  <= $signed(e1.yaw_sin);
    invx2 <= e1.inv_half_x;
    invz2 <= e1.inv_half_z;
    box2  <= (e1.shape_kind == rspn_pkg::SHAPE_BOX);

    // rotation products and squared distance terms
    xc3   <= dx2 * cos2;
    zs3   <= dz2 * sin2;
    zc3   <= dz2 * cos2;
    xs3   <= dx2 * sin2;
    dxx3  <= 49'(mdx * mdx);
    dzz3  <= 49'(mdz * mdz);
    invx3 <= invx2;
    invz3 <= invz2;
    box3  <= box2;

    // local frame offset
    lx4   <= {xc3[40], xc3} + {zs3[40], zs3};
    lz4   <= {zc3[40], zc3} - {xs3[40], xs3};
    d2_4  <= {1'b0, dxx3} + {1'b0, dzz3};
    invx4 <= invx3;
    invz4 <= invz3;
    box4  <= box3;

    // scale by reciprocal half extents
    nx5  <= lx4 * $signed({1'b0, invx4});
    nz5  <= lz4 * $signed({1'b0, invz4});
    d2_5 <= d2_4;
    box5 <= box4;

    // per-axis bound, magnitudes cut to 30 fraction bits
    inb6 <= (mnx <= (63'd1 << ONE_SH)) && (mnz <= (63'd1 << ONE_SH));
    a6   <= mnx[rspn_pkg::ND_DROP+30:rspn_pkg::ND_DROP];
    b6   <= mnz[rspn_pkg::ND_DROP+30:rspn_pkg::ND_DROP];
    d2_6 <= d2_5;
    box6 <= box5;

    aa7  <= 62'(a6 * a6);
    bb7  <= 62'(b6 * b6);
    inb7 <= inb6;
    d2_7 <= d2_6;
    box7 <= box6;

    hit8 <= inb7 && (box7 || (sum_ab <= (63'd1 << 60)));
    d2_8 <= d2_7;

    // nearest tracking; strict compare keeps the lower slot on a tie
    if (cmd.load_point) begin
      found <= 1'b0;
    end else if (v[8] && hit8 && (!found || d2_8 < best_d2)) begin
      found   <= 1'b1;
      best    <= idx8;
      best_d2 <= d2_8;
    end

    if (cmd.load_out) begin
      m_tuser[0]    <= found;
      m_tdata[5:0]  <= found ? best : '0;
      m_tdata[56:6] <= found ? {1'b0, best_d2} : '0;
      m_tdata[63:57] <= '0;
    end
  end

endmodule

// ===== sv/rotated_shape_pick_nearest.sv =====
// Top level of the rotated shape pick: nearest containing footprint search.
// Instantiates rspn_ctrl and rspn_dp; uses rspn_pkg.
//
// Usage:
//   Input stream (s_*): one transfer per item. s_tuser is mode: 0 writes the
//   table slot given in s_tdata, 1 queries the point in s_tdata. A write
//   gives no result.
//   Output stream (m_*): one transfer per query. m_tuser is hit, m_tdata
//   carries nearest_slot and nearest_dist2 (both zero when there is no hit).
//   Config: cfg_we with cfg_wdata sets active_count; write it only while
//   the block is idle. Counts above 64 search all 64 slots.
//   Sequencing: a query walks slots 0..n-1 one per cycle through the table
//   read port into an eight-stage test pipeline, then waits for the pipeline
//   to empty; with n of 0 it goes straight to the wait. The next item can be
//   accepted in the cycle after the result loads. The single read port of
//   the table memory sets the one-slot-per-cycle walk. One item is in work
//   at a time; s_tready is high only between items.
//   Stall: the result sits in the output register; the next item is
//   accepted meanwhile, and a query that finishes before the receiver takes
//   the previous result holds until it does.
//   Reset: rst (synchronous) clears control state and active_count to 0;
//   table contents are undefined until written.
module rotated_shape_pick_nearest (
  input  logic         clk,
  input  logic         rst,
  // s_tdata fields, low bit up: slot, center_x, center_z, yaw_cos, yaw_sin,
  // inv_half_x, inv_half_z, shape_kind, point_x, point_z
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [175:0] s_tdata,
  // s_tuser fields: mode
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata fields, low bit up: nearest_slot, nearest_dist2, zero pad
  output logic [63:0]  m_tdata,
  // m_tuser fields: hit
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  rspn_pkg::cmd_t    cmd;
  rspn_pkg::status_t status;

  // sequencer: handshake, slot walk, drain and output valid
  rspn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .mode      (s_tuser[0]),
    .slot      (s_tdata[5:0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .cmd       (cmd)
  );

  // table, test pipeline, nearest tracking, output register
  rspn_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ===== tb/sv/tb_rotated_shape_pick_nearest.sv =====
// Self-checking testbench for rotated_shape_pick_nearest: footprint table writes,
// nearest-hit queries, active_count settings, idling and back-pressure on both streams.
// Depends on rspn_pkg and the rotated_shape_pick_nearest top level.
`timescale 1ns / 100ps

module tb_rotated_shape_pick_nearest;

  // shape codes besides the box from the package; code three tests like a disc
  localparam logic [1:0] SHAPE_DISC    = 2'd0;
  localparam logic [1:0] SHAPE_ELLIPSE = 2'd2;
  localparam logic [1:0] SHAPE_ODD     = 2'd3;

  localparam longint UNIT_ONE     = 64'sd1 <<< rspn_pkg::ND_FRAC;  // 1.0 of the scaled offset
  localparam longint DISC_BOUND   = 64'sd1 <<< 60;
  localparam int     SETTLE       = 100;   // longer than a full-table search
  localparam int     IDLE_LIMIT   = 5000;  // cycles without any transfer
  localparam int     HOLD_CYCLES  = 400;   // long receiver hold-off

  // s_tdata layout, low bits last in the list
  typedef struct packed {
    logic [rspn_pkg::POS_W-1:0]   point_z;
    logic [rspn_pkg::POS_W-1:0]   point_x;
    logic [rspn_pkg::SHAPE_W-1:0] shape_kind;
    logic [rspn_pkg::INV_W-1:0]   inv_half_z;
    logic [rspn_pkg::INV_W-1:0]   inv_half_x;
    logic [rspn_pkg::TRIG_W-1:0]  yaw_sin;
    logic [rspn_pkg::TRIG_W-1:0]  yaw_cos;
    logic [rspn_pkg::POS_W-1:0]   center_z;
    logic [rspn_pkg::POS_W-1:0]   center_x;
    logic [rspn_pkg::SLOT_W-1:0]  slot;
  } item_t;

  typedef struct packed {
    logic                        hit;
    logic [rspn_pkg::SLOT_W-1:0] slot;
    logic [rspn_pkg::DIST_W-1:0] dist2;
  } pick_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [175:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_we;
  logic [6:0]   cfg_wdata;

  rotated_shape_pick_nearest DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the footprint table and the search count.
  longint     fp_cx    [rspn_pkg::MAX_ENTRIES];
  longint     fp_cz    [rspn_pkg::MAX_ENTRIES];
  longint     fp_cos   [rspn_pkg::MAX_ENTRIES];
  longint     fp_sin   [rspn_pkg::MAX_ENTRIES];
  longint     fp_inv_x [rspn_pkg::MAX_ENTRIES];
  longint     fp_inv_z [rspn_pkg::MAX_ENTRIES];
  logic [1:0] fp_shape [rspn_pkg::MAX_ENTRIES];
  int unsigned search_count;

  pick_t expected_picks[$];
  pick_t front_pick;

  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_request;
  int unsigned hold_left;

  // ---------------------------------------------------------------------------
  // Clock (the single reset at the start is driven in the sequence below)
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Offset rotated into the entry frame, scaled by the inverse half extents,
  // then checked against the unit square or the unit disc.
  function automatic bit footprint_holds(input int unsigned idx, input longint dx,
                                         input longint dz);
    longint lx, lz, nx, nz, a, b;
    lx = dx * fp_cos[idx] + dz * fp_sin[idx];
    lz = dz * fp_cos[idx] - dx * fp_sin[idx];
    nx = magnitude(lx * fp_inv_x[idx]);
    nz = magnitude(lz * fp_inv_z[idx]);
    if (nx > UNIT_ONE || nz > UNIT_ONE) return 1'b0;
    if (fp_shape[idx] == rspn_pkg::SHAPE_BOX) return 1'b1;
    a = nx >>> rspn_pkg::ND_DROP;
    b = nz >>> rspn_pkg::ND_DROP;
    return (a * a + b * b) <= DISC_BOUND;
  endfunction

  // Nearest containing center; strict less-than keeps the lower slot on a tie.
  function automatic pick_t pick_nearest(input longint px, input longint pz);
    pick_t       r;
    int unsigned n;
    int unsigned i;
    longint      dx, dz, d2, best_d2;
    r = '0;
    best_d2 = 0;
    n = (search_count > rspn_pkg::MAX_ENTRIES) ? rspn_pkg::MAX_ENTRIES : search_count;
    for (i = 0; i < n; i++) begin
      dx = px - fp_cx[i];
      dz = pz - fp_cz[i];
      if (footprint_holds(i, dx, dz)) begin
        d2 = dx * dx + dz * dz;
        if (!r.hit || d2 < best_d2) begin
          r.hit   = 1'b1;
          r.slot  = i[rspn_pkg::SLOT_W-1:0];
          best_d2 = d2;
        end
      end
    end
    r.dist2 = best_d2[rspn_pkg::DIST_W-1:0];
    return r;
  endfunction

  function automatic void store_footprint(input item_t it);
    fp_cx[it.slot]    = longint'($signed(it.center_x));
    fp_cz[it.slot]    = longint'($signed(it.center_z));
    fp_cos[it.slot]   = longint'($signed(it.yaw_cos));
    fp_sin[it.slot]   = longint'($signed(it.yaw_sin));
    fp_inv_x[it.slot] = longint'(it.inv_half_x);
    fp_inv_z[it.slot] = longint'(it.inv_half_z);
    fp_shape[it.slot] = it.shape_kind;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Item with every bit random; the fields a given mode ignores stay that way.
  function automatic item_t noise_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return item_t'(raw[175:0]);
  endfunction

  function automatic item_t make_footprint(input int unsigned slot, input longint cx,
                                           input longint cz, input longint c,
                                           input longint s, input longint ix,
                                           input longint iz, input logic [1:0] shape);
    item_t it;
    it = noise_item();
    it.slot       = slot[rspn_pkg::SLOT_W-1:0];
    it.center_x   = cx[rspn_pkg::POS_W-1:0];
    it.center_z   = cz[rspn_pkg::POS_W-1:0];
    it.yaw_cos    = c[rspn_pkg::TRIG_W-1:0];
    it.yaw_sin    = s[rspn_pkg::TRIG_W-1:0];
    it.inv_half_x = ix[rspn_pkg::INV_W-1:0];
    it.inv_half_z = iz[rspn_pkg::INV_W-1:0];
    it.shape_kind = shape;
    return it;
  endfunction

  function automatic item_t make_point(input longint px, input longint pz);
    item_t it;
    it = noise_item();
    it.point_x = px[rspn_pkg::POS_W-1:0];
    it.point_z = pz[rspn_pkg::POS_W-1:0];
    return it;
  endfunction

  // Mostly a proper rotation with sane extents around a shared cluster, so
  // that queries land in several overlapping footprints; the rest is noise.
  function automatic item_t random_footprint(input int unsigned slot);
    item_t       it;
    int          c, s;
    int unsigned hx, hz, pick, src;
    it = noise_item();
    it.slot = slot[rspn_pkg::SLOT_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 10) return it;
    c = int'($urandom_range(0, 32768)) - 16384;
    s = $rtoi($sqrt(real'(16384 * 16384 - c * c)) + 0.5);
    if ($urandom_range(0, 1)) s = -s;
    hx = $urandom_range(32, 5120);  // 1/8 m .. 20 m in Q16.8 units
    hz = $urandom_range(32, 5120);
    it.yaw_cos    = c[rspn_pkg::TRIG_W-1:0];
    it.yaw_sin    = s[rspn_pkg::TRIG_W-1:0];
    it.inv_half_x = (pick < 15) ? '0 : rspn_pkg::INV_W'(32'h0100_0000 / hx);
    it.inv_half_z = (pick >= 15 && pick < 20) ? '0 : rspn_pkg::INV_W'(32'h0100_0000 / hz);
    it.shape_kind = rspn_pkg::SHAPE_W'($urandom_range(0, 3));
    if (pick < 32) begin
      // same center as another slot gives distance ties
      src = $urandom_range(0, rspn_pkg::MAX_ENTRIES - 1);
      it.center_x = fp_cx[src][rspn_pkg::POS_W-1:0];
      it.center_z = fp_cz[src][rspn_pkg::POS_W-1:0];
    end else begin
      it.center_x = rspn_pkg::POS_W'(int'($urandom_range(0, 25600)) - 12800);
      it.center_z = rspn_pkg::POS_W'(int'($urandom_range(0, 25600)) - 12800);
    end
    return it;
  endfunction

  function automatic longint axis_reach(input longint inv);
    longint r;
    r = (inv == 0) ? 64'sd8192 : (64'sd16777216 / inv);
    return (r > 64'sd4194304) ? 64'sd4194304 : r;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Mostly a point aimed at a searched footprint, at its center or out to just past its edge.
  function automatic item_t random_query();
    item_t       it;
    int unsigned pick, n, t;
    longint      reach, span, px, pz, cpx, cpz;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 15) return it;
    n = (search_count > rspn_pkg::MAX_ENTRIES) ? rspn_pkg::MAX_ENTRIES : search_count;
    t = (n == 0) ? $urandom_range(0, rspn_pkg::MAX_ENTRIES - 1) : $urandom_range(0, n - 1);
    reach = axis_reach(fp_inv_x[t]);
    if (axis_reach(fp_inv_z[t]) > reach) reach = axis_reach(fp_inv_z[t]);
    span = (reach * 5) / 4 + 1;
    px = fp_cx[t];
    pz = fp_cz[t];
    if (pick >= 25) begin
      px = px + longint'($urandom_range(0, 32'(2 * span))) - span;
      pz = pz + longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    cpx = clamp_pos(px);
    cpz = clamp_pos(pz);
    it.point_x = cpx[rspn_pkg::POS_W-1:0];
    it.point_z = cpz[rspn_pkg::POS_W-1:0];
    return it;
  endfunction

  // One input transfer. s_tvalid stays high into the next item unless the
  // sender idles first, so it never gets two assignments in one step.
  task automatic push_item(input item_t it, input logic mode);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == rspn_pkg::MODE_QUERY)
      expected_picks.push_back(pick_nearest(longint'($signed(it.point_x)),
                                            longint'($signed(it.point_z))));
    else
      store_footprint(it);
  endtask

  task automatic push_query(input longint px, input longint pz);
    push_item(make_point(px, pz), rspn_pkg::MODE_QUERY);
  endtask

  task automatic await_results();
    s_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  // Register write only with the block idle: results drained, then a pause
  // longer than one full search in case a write is still finishing.
  task automatic set_active_count(input int unsigned value);
    await_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[6:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    search_count = value & 32'h7F;
  endtask

  function automatic int unsigned pick_count(input int unsigned k);
    case (k)
      0:       return 127;
      1:       return 64;
      2:       return 1;
      3:       return 0;
      4:       return 65;
      5:       return 100;
      6:       return $urandom_range(0, 127);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Count is zero after reset: nothing is searched, so no hit.
  task automatic test_empty_search();
    push_query(64'sd8388607, -64'sd8388608);
  endtask

  // Hand-built footprints: every shape code, boundary points, a distance tie,
  // an unbounded axis, out-of-range trig and position extremes.
  task automatic test_directed_shapes();
    push_item(make_footprint(0, 0, 0, 16384, 0, 32768, 32768, SHAPE_DISC),
              rspn_pkg::MODE_WRITE);
    push_item(make_footprint(1, 256, 0, 0, 16384, 65536, 16384, rspn_pkg::SHAPE_BOX),
              rspn_pkg::MODE_WRITE);
    push_item(make_footprint(2, -512, 256, -16384, 0, 21845, 65536, SHAPE_ELLIPSE),
              rspn_pkg::MODE_WRITE);
    // copy of slot 0: equal distance, lower slot must win
    push_item(make_footprint(3, 0, 0, 16384, 0, 32768, 32768, SHAPE_DISC),
              rspn_pkg::MODE_WRITE);
    // zero reciprocal on x: a 45 degree strip of unbounded length
    push_item(make_footprint(4, 0, 0, 11585, 11585, 0, 1048575, SHAPE_ODD),
              rspn_pkg::MODE_WRITE);
    push_item(make_footprint(5, -8388608, 8388607, 32767, -32768, 1048575, 1048575,
                             rspn_pkg::SHAPE_BOX), rspn_pkg::MODE_WRITE);
    set_active_count(6);
    push_query(0, 0);
    push_query(512, 0);          // exactly on the disc rim
    push_query(513, 0);          // just outside it
    push_query(256, 0);
    push_query(-512, 256);
    push_query(64'sd8388607, 64'sd8388607);
    push_query(-64'sd8388608, 64'sd8388607);
    push_query(-64'sd8388608, -64'sd8388608);
    set_active_count(1);
    push_query(256, 0);
  endtask

  // Every slot gets written before any count above six is used.
  task automatic test_fill_table();
    int unsigned i;
    for (i = 0; i < rspn_pkg::MAX_ENTRIES; i++)
      push_item(random_footprint(i), rspn_pkg::MODE_WRITE);
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned first_setting);
    int unsigned blk;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (blk = 0; blk < 4; blk++) begin
      set_active_count(pick_count(first_setting + blk));
      repeat (65) begin
        if ($urandom_range(0, 3) == 0)
          push_item(random_footprint($urandom_range(0, rspn_pkg::MAX_ENTRIES - 1)),
                    rspn_pkg::MODE_WRITE);
        else
          push_item(random_query(), rspn_pkg::MODE_QUERY);
      end
    end
  endtask

  // Receiver holds off for a long stretch while queries keep coming, so the
  // output register fills and s_tready drops.
  task automatic test_result_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_active_count(64);
    hold_request = 1'b1;
    repeat (12) push_item(random_query(), rspn_pkg::MODE_QUERY);
  endtask

  // Sender stops until every pending result is back, then resumes.
  task automatic test_drain_pause();
    repeat (5) push_item(random_query(), rspn_pkg::MODE_QUERY);
    await_results();
    repeat (5) push_item(random_query(), rspn_pkg::MODE_QUERY);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    search_count = 0;
    mismatches   = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_search();
    test_directed_shapes();
    test_fill_table();
    test_random_traffic(31, 85, 0);
    test_random_traffic(85, 31, 4);
    test_random_traffic(0, 0, 8);
    test_result_backpressure();
    test_drain_pause();

    await_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("PASS rotated_shape_pick_nearest");
    else
      $display("FAIL rotated_shape_pick_nearest");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog; both sample values as they stood at the edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: hit=%0d slot=%0d dist2=%0d", $time,
                 m_tuser[0], m_tdata[5:0], m_tdata[56:6]);
      end else begin
        front_pick = expected_picks.pop_front();
        if (m_tuser[0] !== front_pick.hit || m_tdata[5:0] !== front_pick.slot ||
            m_tdata[56:6] !== front_pick.dist2) begin
          mismatches++;
          $display("%0t mismatch: exp hit=%0d slot=%0d d2=%0d, got hit=%0d slot=%0d d2=%0d",
                   $time, front_pick.hit, front_pick.slot, front_pick.dist2,
                   m_tuser[0], m_tdata[5:0], m_tdata[56:6]);
        end
      end
    end

    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no transfer for %0d cycles, %0d results pending", $time, IDLE_LIMIT,
               expected_picks.size());
      $display("FAIL rotated_shape_pick_nearest");
      $finish;
    end
  end

endmodule
